// File: design/slot_table_pool_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot table pool allocator
// Immediate-implication and next-cycle checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef SLOT_TABLE_POOL_ALLOCATOR_ASSERT_SVH
`define SLOT_TABLE_POOL_ALLOCATOR_ASSERT_SVH

// check cons in the same cycle as ante
`define STPA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stpa assertion failed");

// check cons in the cycle after ante
`define STPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stpa assertion failed");

`endif

// File: design/stpa_pkg.sv
// ----------------------------------------------------------------------------
// stpa_pkg
// Shared types and constants of the slot table pool allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stpa_pkg;

   localparam int SLOT_COUNT_DEFAULT = 32;
   localparam int POOL_BYTES_DEFAULT = 4096;
   localparam int FIELD_W            = 12;

   localparam logic ACTION_ALLOCATE = 1'b0;
   localparam logic ACTION_RELEASE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ALLOCATED = 2'd0,
      STATUS_NO_SLOT   = 2'd1,
      STATUS_NO_SPACE  = 2'd2,
      STATUS_RELEASED  = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ALLOCATE = 1'b0,
      CMD_RELEASE  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      logic               action;
      logic [FIELD_W-1:0] alloc_length;
      logic [FIELD_W-1:0] release_offset;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] granted_offset;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [FIELD_W-1:0] length;
      logic [FIELD_W-1:0] offset;
   } cmd_type;

endpackage

// File: design/slot_table_pool_allocator.sv
// ----------------------------------------------------------------------------
// slot_table_pool_allocator
// First-fit region allocator over a slot table of offset/length reservations.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port: an allocate or release
// transaction is taken when req_push is high and req_full is low. Results
// leave the same way: the oldest result sits on rsp_data while rsp_empty is
// low and is taken when rsp_pop is high.
// The front queues up to two requests; the engine behind it walks the slot
// RAM through its single read port, one slot per cycle, then writes back.
// The engine takes the next transaction only after it has finished the last
// one and returned to idle, so it works on one transaction at a time.
// Reset empties both queues and marks every slot free at once through
// per-slot valid flags; no clearing pass is run.
// When rsp_pop stays low, one finished result is held; the engine keeps
// working on the next transaction and waits before its write-back until
// the result is taken, and req_full rises once two requests are queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_table_pool_allocator #(
   parameter int SLOT_COUNT = stpa_pkg::SLOT_COUNT_DEFAULT,
   parameter int POOL_BYTES = stpa_pkg::POOL_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  stpa_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output stpa_pkg::rsp_type rsp_data
);

   logic              cmd_valid;
   logic              cmd_pop;
   stpa_pkg::cmd_type cmd_data;

   stpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   stpa_back #(
      .SLOT_COUNT (SLOT_COUNT),
      .POOL_BYTES (POOL_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/stpa_ram.sv
// ----------------------------------------------------------------------------
// stpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/stpa_front.sv
// ----------------------------------------------------------------------------
// stpa_front
// Request intake: classifies each transaction and queues it for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpa_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  stpa_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output stpa_pkg::cmd_type cmd_data
);

   stpa_pkg::cmd_type entry_ff [2];
   stpa_pkg::cmd_type cmd_in;
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              push_ok;
   logic              pop_ok;

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = entry_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      cmd_in.kind   = (req_data.action == stpa_pkg::ACTION_RELEASE) ?
                      stpa_pkg::CMD_RELEASE : stpa_pkg::CMD_ALLOCATE;
      cmd_in.length = req_data.alloc_length;
      cmd_in.offset = req_data.release_offset;
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_ok) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         unique case ({push_ok, pop_ok})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: design/stpa_back.sv
// ----------------------------------------------------------------------------
// stpa_back
// Slot engine: scans the slot table one slot per cycle and writes back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slot_table_pool_allocator_assert.svh"

module stpa_back #(
   parameter int SLOT_COUNT = stpa_pkg::SLOT_COUNT_DEFAULT,
   parameter int POOL_BYTES = stpa_pkg::POOL_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  stpa_pkg::cmd_type cmd_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output stpa_pkg::rsp_type rsp_data
);

   localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int LEN_W   = stpa_pkg::FIELD_W;
   localparam int OFF_W   = $clog2(POOL_BYTES);
   localparam int POS_W   = $clog2(POOL_BYTES + 8192);
   localparam int ENTRY_W = OFF_W + LEN_W;
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOT_COUNT - 1);
   localparam logic [POS_W-1:0] POOL_LIMIT = POS_W'(POOL_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   stpa_pkg::cmd_type  cmd_ff, cmd_in;
   logic [POS_W-1:0]   cursor_ff, cursor_in;
   logic [POS_W-1:0]   end_ff, end_in;
   logic               fail_ff, fail_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic               issue_ff, issue_in;
   logic [IDX_W-1:0]   issue_idx_ff, issue_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               pre_vld_ff, pre_vld_in;
   logic [IDX_W-1:0]   pre_idx_ff, pre_idx_in;
   logic               pre_used_ff, pre_used_in;
   logic [POS_W-1:0]   pre_lo_ff, pre_lo_in;
   logic [POS_W-1:0]   pre_hi_ff, pre_hi_in;
   logic [POS_W-1:0]   pre_hilen_ff, pre_hilen_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic               rsp_vld_ff, rsp_vld_in;
   stpa_pkg::rsp_type  rsp_ff, rsp_in;

   logic               ram_wr_en;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [POS_W-1:0]   rd_lo;
   logic [POS_W-1:0]   rd_hi;
   logic               in_cur;
   logic               in_end;
   logic [POS_W-1:0]   cur1;
   logic [POS_W-1:0]   end1;
   logic [POS_W-1:0]   cur2;
   logic [POS_W-1:0]   end2;
   logic               rsp_room;

   stpa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pick_ff),
      .wr_data (ram_wr_data),
      .rd_en   (issue_ff),
      .rd_addr (issue_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_empty   = !rsp_vld_ff;
   assign rsp_data    = rsp_ff;
   assign rsp_room    = !rsp_vld_ff || rsp_pop;
   assign ram_wr_data = {cursor_ff[OFF_W-1:0], cmd_ff.length};

   always_comb begin
      rd_lo = POS_W'(ram_rd_data[ENTRY_W-1 -: OFF_W]);
      rd_hi = rd_lo + POS_W'(ram_rd_data[LEN_W-1:0]);
   end

   always_comb begin
      in_cur = (pre_lo_ff <= cursor_ff) && (cursor_ff < pre_hi_ff);
      cur1   = in_cur ? pre_hi_ff : cursor_ff;
      end1   = in_cur ? pre_hilen_ff : end_ff;
      in_end = (pre_lo_ff <= end1) && (end1 < pre_hi_ff);
      cur2   = in_end ? pre_hi_ff : cur1;
      end2   = in_end ? pre_hilen_ff : end1;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cursor_in    = cursor_ff;
      end_in       = end_ff;
      fail_in      = fail_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      issue_in     = issue_ff;
      issue_idx_in = issue_idx_ff;
      rd_vld_in    = issue_ff;
      rd_idx_in    = issue_idx_ff;
      pre_vld_in   = rd_vld_ff;
      pre_idx_in   = rd_idx_ff;
      pre_used_in  = valid_ff[rd_idx_ff];
      pre_lo_in    = pre_used_in ? rd_lo : '0;
      pre_hi_in    = pre_used_in ? rd_hi : '0;
      pre_hilen_in = pre_hi_in + POS_W'(cmd_ff.length);
      valid_in     = valid_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      ram_wr_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop      = 1'b1;
               cmd_in       = cmd_data;
               cursor_in    = POS_W'(1);
               end_in       = POS_W'(1) + POS_W'(cmd_data.length);
               fail_in      = 1'b0;
               found_in     = 1'b0;
               pick_in      = '0;
               issue_in     = 1'b1;
               issue_idx_in = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               issue_idx_in = issue_idx_ff + IDX_W'(1);
               if (issue_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end
            end
            if (pre_vld_ff) begin
               if (!found_ff && !pre_used_ff) begin
                  found_in = 1'b1;
                  pick_in  = pre_idx_ff;
               end
               if (cmd_ff.kind == stpa_pkg::CMD_RELEASE) begin
                  if (pre_used_ff && pre_lo_ff == POS_W'(cmd_ff.offset)) begin
                     valid_in[pre_idx_ff] = 1'b0;
                  end
               end else if (!fail_ff) begin
                  cursor_in = cur2;
                  end_in    = end2;
                  fail_in   = (cur2 >= POOL_LIMIT) || (end2 >= POOL_LIMIT);
               end
               if (pre_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_room) begin
               rsp_vld_in            = 1'b1;
               rsp_in.granted_offset = '0;
               priority if (cmd_ff.kind == stpa_pkg::CMD_RELEASE) begin
                  rsp_in.status = stpa_pkg::STATUS_RELEASED;
               end else if (!found_ff) begin
                  rsp_in.status = stpa_pkg::STATUS_NO_SLOT;
               end else if (fail_ff) begin
                  rsp_in.status = stpa_pkg::STATUS_NO_SPACE;
               end else begin
                  rsp_in.status         = stpa_pkg::STATUS_ALLOCATED;
                  rsp_in.granted_offset = cursor_ff[LEN_W-1:0];
                  ram_wr_en             = 1'b1;
                  valid_in[pick_ff]     = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         issue_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
         pre_vld_ff <= 1'b0;
         valid_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         issue_ff   <= issue_in;
         rd_vld_ff  <= rd_vld_in;
         pre_vld_ff <= pre_vld_in;
         valid_ff   <= valid_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      cmd_ff       <= cmd_in;
      cursor_ff    <= cursor_in;
      end_ff       <= end_in;
      fail_ff      <= fail_in;
      found_ff     <= found_in;
      pick_ff      <= pick_in;
      issue_idx_ff <= issue_idx_in;
      rd_idx_ff    <= rd_idx_in;
      pre_idx_ff   <= pre_idx_in;
      pre_used_ff  <= pre_used_in;
      pre_lo_ff    <= pre_lo_in;
      pre_hi_ff    <= pre_hi_in;
      pre_hilen_ff <= pre_hilen_in;
      rsp_ff       <= rsp_in;
   end

   `STPA_ASSERT_IMPLY(a_process_in_scan, clock, reset, pre_vld_ff, state_ff == ST_SCAN)
   `STPA_ASSERT_IMPLY(a_granted_zero, clock, reset,
      rsp_vld_ff && rsp_ff.status != stpa_pkg::STATUS_ALLOCATED,
      rsp_ff.granted_offset == '0)
   `STPA_ASSERT_NEXT(a_one_new_slot, clock, reset, 1'b1,
      $countones(valid_ff) <= $countones($past(valid_ff)) + 1)
   `STPA_ASSERT_NEXT(a_alloc_marks_slot, clock, reset,
      state_ff == ST_FINISH && rsp_room &&
      cmd_ff.kind == stpa_pkg::CMD_ALLOCATE && found_ff && !fail_ff,
      valid_ff[$past(pick_ff)])

endmodule
